/* hdl/sm4_pkg.sv */
package sm4_pkg;

  localparam int MaxItems = 64;
  localparam int AddrW    = $clog2(MaxItems);
  localparam int CntW     = AddrW + 1;
  localparam int NumCh    = 4;
  localparam int ScoreW   = 16;
  localparam int ExpW     = 17;
  localparam int SumW     = 23;
  localparam int ProbW    = 16;
  localparam int FracBits = 10;

  // log2(e) in Q16
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_EXPU,
    ST_EXPF,
    ST_EXPK,
    ST_RD2,
    ST_DIVI,
    ST_DIVS
  } sm4_state_e;

  // 2^(-2^(j-10)) in Q16
  function automatic logic [15:0] half_pow(input logic [3:0] j);
    logic [15:0] r;
    unique case (j)
      4'd0:    r = 16'd65492;
      4'd1:    r = 16'd65447;
      4'd2:    r = 16'd65359;
      4'd3:    r = 16'd65182;
      4'd4:    r = 16'd64830;
      4'd5:    r = 16'd64132;
      4'd6:    r = 16'd62757;
      4'd7:    r = 16'd60097;
      4'd8:    r = 16'd55109;
      4'd9:    r = 16'd46341;
      default: r = 16'd65535;
    endcase
    return r;
  endfunction

endpackage

/* hdl/softmax_four_channel.sv */
// load: one word per cycle while busy is low, the word with is_last_i closes the list
// compute: per stored item 49 cycles of exp-and-sum (one shared exp unit, 12 cycles a
//   channel), then 73 cycles of divide per item (one 17-step serial divider a channel)
// results come out one every 73 cycles, each for a single cycle; the receiver cannot stall
// reset: asynchronous active low, empties the list, maxima to most negative, sums to zero
module softmax_four_channel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [sm4_pkg::ScoreW-1:0] class_score_i,
  input  logic signed [sm4_pkg::ScoreW-1:0] instance_score_i,
  input  logic signed [sm4_pkg::ScoreW-1:0] global_class_score_i,
  input  logic signed [sm4_pkg::ScoreW-1:0] global_instance_score_i,
  input  logic                            is_last_i,
  output logic                            valid_o,
  output logic [sm4_pkg::ProbW-1:0]       class_prob_o,
  output logic [sm4_pkg::ProbW-1:0]       instance_prob_o,
  output logic [sm4_pkg::ProbW-1:0]       global_class_prob_o,
  output logic [sm4_pkg::ProbW-1:0]       global_instance_prob_o,
  output logic                            last_result_o
);
  import sm4_pkg::*;

  // score memory, one entry per item, four channels packed low to high
  logic [NumCh*ScoreW-1:0] score_mem [MaxItems];
  logic [NumCh*ScoreW-1:0] srd_q;
  logic                    swe;
  // exp memory, filled in the exp pass and read back in the divide pass
  logic [NumCh*ExpW-1:0]   exp_mem [MaxItems];
  logic [NumCh*ExpW-1:0]   erd_q;
  logic                    ewe;

  sm4_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [1:0]       ch_q, ch_d;
  logic [3:0]       j_q, j_d;
  logic signed [ScoreW-1:0] max_q [NumCh];
  logic signed [ScoreW-1:0] max_d [NumCh];
  logic [SumW-1:0]  sum_q [NumCh];
  logic [SumW-1:0]  sum_d [NumCh];
  logic             valid_q, valid_d;

  // datapath registers, no reset
  logic [ExpW-1:0]  u_q, u_d;
  logic [ExpW-1:0]  e_q, e_d;
  logic [ExpW-1:0]  ebuf_q [3];
  logic [ExpW-1:0]  ebuf_d [3];
  logic [ProbW-1:0] pbuf_q [3];
  logic [ProbW-1:0] pbuf_d [3];
  logic [SumW:0]    rem_q, rem_d;
  logic [ExpW-1:0]  num_q, num_d;
  logic [ExpW-1:0]  quo_q, quo_d;
  logic [4:0]       step_q, step_d;
  logic [ProbW-1:0] out_q [NumCh];
  logic [ProbW-1:0] out_d [NumCh];
  logic             olast_q, olast_d;

  // combinational helpers
  logic [NumCh*ScoreW-1:0] wr_word;
  logic                    accept;
  logic                    room;
  logic signed [ScoreW-1:0] in_sc [NumCh];
  logic [ScoreW-1:0] x_sel;
  logic [ScoreW-1:0] t_val;
  logic [33:0]       u_full;
  logic [32:0]       f_full;
  logic [6:0]        k_val;
  logic [ExpW-1:0]   ex_val;
  logic [ExpW-1:0]   e_sel;
  logic [SumW-1:0]   s_sel;
  logic [32:0]       num_full;
  logic [SumW:0]     r2;
  logic              qbit;
  logic [ExpW-1:0]   quo_new;
  logic [ProbW-1:0]  p_sat;
  logic              last_item;

  assign in_sc[0] = class_score_i;
  assign in_sc[1] = instance_score_i;
  assign in_sc[2] = global_class_score_i;
  assign in_sc[3] = global_instance_score_i;
  assign wr_word  = {global_instance_score_i, global_class_score_i,
                     instance_score_i, class_score_i};

  assign accept    = start && (state_q == ST_LOAD);
  assign room      = cnt_q < CntW'(MaxItems);
  assign last_item = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  // exp unit: t = max - x, u = t * log2(e), then ten conditional
  // multiplies by the fraction table and a final shift by the integer part
  assign x_sel  = srd_q[16*ch_q +: ScoreW];
  assign t_val  = max_q[ch_q] - x_sel;
  assign u_full = 34'(t_val) * 34'(Log2eQ16) + 34'd32768;
  assign f_full = 33'(e_q) * 33'(half_pow(j_q)) + 33'd32768;
  assign k_val  = u_q[ExpW-1:FracBits];
  assign ex_val = (k_val >= 7'd17) ? '0 : (e_q >> k_val[4:0]);

  // serial divider: p = (e * 2^16 + sum / 2) / sum, one quotient bit a cycle
  assign e_sel    = erd_q[17*ch_q +: ExpW];
  assign s_sel    = sum_q[ch_q];
  assign num_full = {e_sel, 16'd0} + 33'(s_sel >> 1);
  assign r2       = {rem_q[SumW-1:0], num_q[ExpW-1]};
  assign qbit     = r2 >= {1'b0, s_sel};
  assign quo_new  = {quo_q[ExpW-2:0], qbit};
  assign p_sat    = quo_new[ExpW-1] ? '1 : quo_new[ProbW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ch_d    = ch_q;
    j_d     = j_q;
    max_d   = max_q;
    sum_d   = sum_q;
    valid_d = 1'b0;
    u_d     = u_q;
    e_d     = e_q;
    ebuf_d  = ebuf_q;
    pbuf_d  = pbuf_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    step_d  = step_q;
    out_d   = out_q;
    olast_d = olast_q;
    swe     = 1'b0;
    ewe     = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            swe   = 1'b1;
            cnt_d = cnt_q + CntW'(1);
            for (int c = 0; c < NumCh; c++) begin
              if (in_sc[c] > max_q[c]) max_d[c] = in_sc[c];
            end
          end
          if (is_last_i) begin
            idx_d   = '0;
            ch_d    = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_EXPU;
      end
      ST_EXPU: begin
        u_d     = u_full[32:16];
        e_d     = ExpW'(65536);
        j_d     = 4'd9;
        state_d = ST_EXPF;
      end
      ST_EXPF: begin
        if (u_q[j_q]) e_d = f_full[32:16];
        j_d = j_q - 4'd1;
        if (j_q == 4'd0) state_d = ST_EXPK;
      end
      ST_EXPK: begin
        sum_d[ch_q] = sum_q[ch_q] + SumW'(ex_val);
        if (ch_q == 2'd3) begin
          ewe  = 1'b1;
          ch_d = '0;
          if (last_item) begin
            idx_d   = '0;
            state_d = ST_RD2;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = ST_RD;
          end
        end else begin
          ebuf_d[ch_q] = ex_val;
          ch_d         = ch_q + 2'd1;
          state_d      = ST_EXPU;
        end
      end
      ST_RD2: begin
        state_d = ST_DIVI;
      end
      ST_DIVI: begin
        rem_d   = (SumW+1)'(num_full[32:17]);
        num_d   = num_full[16:0];
        quo_d   = '0;
        step_d  = 5'd16;
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        rem_d  = qbit ? (r2 - {1'b0, s_sel}) : r2;
        num_d  = {num_q[ExpW-2:0], 1'b0};
        quo_d  = quo_new;
        step_d = step_q - 5'd1;
        if (step_q == 5'd0) begin
          if (ch_q == 2'd3) begin
            out_d[0] = pbuf_q[0];
            out_d[1] = pbuf_q[1];
            out_d[2] = pbuf_q[2];
            out_d[3] = p_sat;
            olast_d  = last_item;
            valid_d  = 1'b1;
            ch_d     = '0;
            if (last_item) begin
              cnt_d   = '0;
              for (int c = 0; c < NumCh; c++) begin
                max_d[c] = {1'b1, {(ScoreW-1){1'b0}}};
                sum_d[c] = '0;
              end
              state_d = ST_LOAD;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = ST_RD2;
            end
          end else begin
            pbuf_d[ch_q] = p_sat;
            ch_d         = ch_q + 2'd1;
            state_d      = ST_DIVI;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      ch_q    <= '0;
      j_q     <= '0;
      valid_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        max_q[c] <= {1'b1, {(ScoreW-1){1'b0}}};
        sum_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ch_q    <= ch_d;
      j_q     <= j_d;
      valid_q <= valid_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    e_q     <= e_d;
    ebuf_q  <= ebuf_d;
    pbuf_q  <= pbuf_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    out_q   <= out_d;
    olast_q <= olast_d;
  end

  // memories: one write port, one registered read port at the current item
  always_ff @(posedge clk_i) begin
    if (swe) score_mem[cnt_q[AddrW-1:0]] <= wr_word;
    srd_q <= score_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ewe) exp_mem[idx_q] <= {ex_val, ebuf_q[2], ebuf_q[1], ebuf_q[0]};
    erd_q <= exp_mem[idx_q];
  end

  assign busy                   = state_q != ST_LOAD;
  assign valid_o                = valid_q;
  assign class_prob_o           = out_q[0];
  assign instance_prob_o        = out_q[1];
  assign global_class_prob_o    = out_q[2];
  assign global_instance_prob_o = out_q[3];
  assign last_result_o          = olast_q;

endmodule

/* hdl/sm4_checker.sv */
module sm4_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic is_last_i,
  input logic valid_o,
  input logic last_result_o
);

  // results never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe on consecutive cycles");

  // a closing word starts the compute phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && is_last_i) |=> busy)
    else $error("closing word did not start compute");

  // results before the final one come while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_result_o) |-> busy)
    else $error("non-final result while idle");

  // the final result releases the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_result_o) |-> !busy)
    else $error("still busy at final result");

endmodule

bind softmax_four_channel sm4_checker u_sm4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .is_last_i     (is_last_i),
  .valid_o       (valid_o),
  .last_result_o (last_result_o)
);
